// File: rtl/core/pmrgba_pkg.sv
// Shared types and constants for the premultiplied ARGB to RGBA converter.
`timescale 1ns / 1ps

package pmrgba_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned RECIP_W = FRAC_W + 1;
  localparam int unsigned NUM_W   = 2 * CH_W;
  localparam int unsigned QUOT_W  = FRAC_W + 1;
  localparam int unsigned REM_W   = CH_W + 1;

  localparam logic [CH_W-1:0] ALPHA_ZERO = '0;
  localparam logic            LAYOUT_BE  = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             last_in;
  } pmrgba_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_out;
  } pmrgba_out_t;

endpackage

// File: rtl/core/premultiplied_argb_to_rgba.sv
// Top level: premultiplied ARGB to straight-alpha RGBA pixel converter.
`timescale 1ns / 1ps
// Pipeline: three divide stages plus the output register, from input accept to
//   output valid.
// Throughput: one item per cycle; the whole pipe holds while out_ready is low
//   and the output register is full.
// Reset (rst_n, synchronous, active low): clear all valid bits and the layout
//   register (AABBGGRR order); payload registers are not reset.

module premultiplied_argb_to_rgba
  import pmrgba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pmrgba_in_t  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pmrgba_out_t out_data,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  // Pipe advance: move everything when the output register is free or drains.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Layout register
  logic layout_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= 1'b0;
    end else if (cfg_we) begin
      layout_r <= cfg_wdata;
    end
  end

  // Reciprocal table floor(2^16 / a), built at elaboration; entry zero unused.
  logic [RECIP_W-1:0] recip_tab [2**CH_W];
  assign recip_tab[0] = '0;
  for (genvar i = 1; i < 2**CH_W; i++) begin : g_recip
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**FRAC_W) / i);
    assign recip_tab[i] = RECIP;
  end

  logic [CH_W-1:0] in_a, in_r, in_g, in_b;
  assign in_a = in_data.pixel_in[31:24];
  assign in_r = in_data.pixel_in[23:16];
  assign in_g = in_data.pixel_in[15:8];
  assign in_b = in_data.pixel_in[7:0];

  logic [RECIP_W-1:0] in_recip;
  assign in_recip = recip_tab[in_a];

  // Three colour lanes share the reciprocal lookup.
  logic [CH_W-1:0] q_r, q_g, q_b;

  pmrgba_div_lane u_lane_r (
    .clk(clk), .en(en), .chan(in_r), .alpha(in_a), .recip(in_recip), .quot(q_r)
  );
  pmrgba_div_lane u_lane_g (
    .clk(clk), .en(en), .chan(in_g), .alpha(in_a), .recip(in_recip), .quot(q_g)
  );
  pmrgba_div_lane u_lane_b (
    .clk(clk), .en(en), .chan(in_b), .alpha(in_a), .recip(in_recip), .quot(q_b)
  );

  // Side band: valid bits, raw pixel (for the alpha-zero pass-through) and last
  // travel alongside the lanes, three stages deep.
  logic             v1_r, v2_r, v3_r;
  logic [PIX_W-1:0] px1_r, px2_r, px3_r;
  logic             last1_r, last2_r, last3_r;
  logic             out_valid_r;
  pmrgba_out_t      out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r   <= in_data.pixel_in;
      last1_r <= in_data.last_in;
      px2_r   <= px1_r;
      last2_r <= last1_r;
      px3_r   <= px2_r;
      last3_r <= last2_r;
    end
  end

  // Output stage: pick pass-through or packed quotient in the chosen order.
  // Full alpha needs no special arm: 255*c/255 is c itself.
  logic [CH_W-1:0]  a3;
  logic [PIX_W-1:0] packed_px;
  pmrgba_out_t      out_data_nxt;

  assign a3 = px3_r[31:24];

  always_comb begin
    if (layout_r == LAYOUT_BE) begin
      packed_px = {q_r, q_g, q_b, a3};
    end else begin
      packed_px = {a3, q_b, q_g, q_r};
    end
    out_data_nxt.pixel_out = (a3 == ALPHA_ZERO) ? px3_r : packed_px;
    out_data_nxt.last_out  = last3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/pmrgba_div_lane.sv
// One colour lane: pipelined floor(255*c/a) by reciprocal multiply and correction.
`timescale 1ns / 1ps

module pmrgba_div_lane
  import pmrgba_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [CH_W-1:0]    chan,
  input  logic [CH_W-1:0]    alpha,
  input  logic [RECIP_W-1:0] recip,
  output logic [CH_W-1:0]    quot
);

  logic [NUM_W-1:0]   n1_r, n2_r;
  logic [RECIP_W-1:0] m1_r;
  logic [CH_W-1:0]    a1_r, a2_r, a3_r;
  logic [QUOT_W-1:0]  q2_r, q3_r;
  logic [REM_W-1:0]   rem3_r;

  logic [NUM_W-1:0]           n1_nxt;
  logic [NUM_W+RECIP_W-1:0]   prod2;
  logic [QUOT_W+CH_W-1:0]     prod3;
  logic [QUOT_W-1:0]          diff3;

  // 255*c as (c << 8) - c
  assign n1_nxt = {chan, {CH_W{1'b0}}} - {{CH_W{1'b0}}, chan};
  assign prod2  = (NUM_W+RECIP_W)'(n1_r) * (NUM_W+RECIP_W)'(m1_r);
  assign prod3  = (QUOT_W+CH_W)'(q2_r) * (QUOT_W+CH_W)'(a2_r);
  // true remainder lies in [0, 2a), so the low bits are exact
  assign diff3  = {1'b0, n2_r} - prod3[QUOT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r   <= n1_nxt;
      m1_r   <= recip;
      a1_r   <= alpha;
      n2_r   <= n1_r;
      a2_r   <= a1_r;
      q2_r   <= prod2[NUM_W+RECIP_W-1:FRAC_W];
      q3_r   <= q2_r;
      a3_r   <= a2_r;
      rem3_r <= diff3[REM_W-1:0];
    end
  end

  // estimate is low by at most one: bump it when the remainder reaches alpha
  assign quot = q3_r[CH_W-1:0] + CH_W'(rem3_r >= {1'b0, a3_r});

endmodule
